/* src/aps_pkg.sv */
package aps_pkg;

  // Field widths
  localparam int unsigned RAW_W    = 16;
  localparam int unsigned MG_W     = 12;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned COUNT_W  = 32;
  localparam int unsigned AXIS_W   = 2;
  localparam int unsigned N_AXES   = 3;

  // Milli-g conversion: |raw * 1000 - bias * 2^14| >> 14, saturated
  localparam int unsigned MG_PER_G  = 1000;
  localparam int unsigned FRAC_BITS = 14;
  localparam int unsigned MG_NUM_W  = 28;
  localparam int unsigned MG_MAX    = (1 << MG_W) - 1;

  localparam int unsigned AVG_DEPTH_DEF = 20;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [MG_W-1:0]   STEP_PRECISION_RST = MG_W'(200);
  localparam logic [TIME_W-1:0] WINDOW_INTERVAL_RST = TIME_W'(500000);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STEP_PRECISION = 3'd0,
    REG_WINDOW_INTERVAL = 3'd1,
    REG_BIAS_X = 3'd2,
    REG_BIAS_Y = 3'd3,
    REG_BIAS_Z = 3'd4
  } aps_reg_e;

  typedef enum logic [AXIS_W-1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } aps_axis_e;

  typedef struct packed {
    logic [MG_W-1:0]               step_precision;
    logic [TIME_W-1:0]             window_interval_us;
    logic [N_AXES-1:0][MG_W-1:0]   bias_mg;
  } cfg_t;

  typedef struct packed {
    logic [N_AXES-1:0][RAW_W-1:0]  raw;
    logic [TIME_W-1:0]             time_us;
  } sample_t;

  typedef struct packed {
    logic                          valid;
    logic [N_AXES-1:0][MG_W-1:0]   avg;
    logic [TIME_W-1:0]             time_us;
  } avg_beat_t;

  typedef struct packed {
    logic                          valid;
    logic [COUNT_W-1:0]            steps_total;
    logic                          step_seen;
    aps_axis_e                     axis_in_use;
  } result_t;

endpackage

/* src/aps_in_if.sv */
interface aps_in_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [aps_pkg::RAW_W-1:0]       raw_x;
  logic signed [aps_pkg::RAW_W-1:0]       raw_y;
  logic signed [aps_pkg::RAW_W-1:0]       raw_z;
  logic [aps_pkg::TIME_W-1:0]             time_us;

  modport source (output valid, output raw_x, output raw_y, output raw_z, output time_us,
                  input ready);
  modport sink (input valid, input raw_x, input raw_y, input raw_z, input time_us,
                output ready);
endinterface

/* src/aps_out_if.sv */
interface aps_out_if;
  logic                                   valid;
  logic                                   ready;
  logic [aps_pkg::COUNT_W-1:0]            steps_total;
  logic                                   step_seen;
  logic [aps_pkg::AXIS_W-1:0]             axis_in_use;

  modport source (output valid, output steps_total, output step_seen, output axis_in_use,
                  input ready);
  modport sink (input valid, input steps_total, input step_seen, input axis_in_use,
                output ready);
endinterface

/* src/aps_ram.sv */
module aps_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/aps_front.sv */
module aps_front #(
  parameter int unsigned AVG_DEPTH = aps_pkg::AVG_DEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                advance_i,
  input  logic                accept_i,
  input  aps_pkg::sample_t    sample_i,
  input  aps_pkg::cfg_t       cfg_i,
  output aps_pkg::avg_beat_t  avg_o
);

  localparam int unsigned SLOT_W  = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
  localparam int unsigned SUM_W   = aps_pkg::MG_W + $clog2(AVG_DEPTH);
  localparam int unsigned SHIFT   = SUM_W + $clog2(AVG_DEPTH);
  localparam int unsigned RECIP_W = SUM_W + 1;
  localparam longint unsigned RECIP =
    ((64'd1 << SHIFT) + longint'(AVG_DEPTH) - 64'd1) / longint'(AVG_DEPTH);
  localparam int unsigned PROD_W  = SUM_W + RECIP_W;
  localparam int unsigned ROW_W   = aps_pkg::N_AXES * aps_pkg::MG_W;
  localparam int unsigned NUM_W   = aps_pkg::MG_NUM_W;

  function automatic logic [aps_pkg::MG_W-1:0] to_mg(
    input logic [aps_pkg::RAW_W-1:0] raw,
    input logic [aps_pkg::MG_W-1:0]  bias
  );
    logic signed [NUM_W-1:0] num;
    logic [NUM_W-1:0]        mag;
    logic [NUM_W-1:0]        whole;
    num = (NUM_W'(signed'(raw)) * NUM_W'(signed'(aps_pkg::MG_PER_G)))
          - (NUM_W'(signed'(bias)) <<< aps_pkg::FRAC_BITS);
    mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    whole = mag >> aps_pkg::FRAC_BITS;
    if (whole > NUM_W'(aps_pkg::MG_MAX)) begin
      return aps_pkg::MG_W'(aps_pkg::MG_MAX);
    end
    return whole[aps_pkg::MG_W-1:0];
  endfunction

  // Read side of the history ring
  logic [SLOT_W-1:0] rd_slot_q;
  logic              fill_q;

  // Stage A: captured sample, history read in flight
  logic              a_valid_q;
  aps_pkg::sample_t  a_sample_q;
  logic [SLOT_W-1:0] a_slot_q;
  logic              a_fill_q;

  // Stage B: running sums
  logic                                 b_valid_q;
  logic [aps_pkg::TIME_W-1:0]           b_time_q;
  logic [aps_pkg::N_AXES-1:0][SUM_W-1:0] sums_q;
  logic [aps_pkg::N_AXES-1:0][SUM_W-1:0] sums_d;

  // Stage C: averages
  logic                                        c_valid_q;
  logic [aps_pkg::TIME_W-1:0]                  c_time_q;
  logic [aps_pkg::N_AXES-1:0][aps_pkg::MG_W-1:0] c_avg_q;
  logic [aps_pkg::N_AXES-1:0][aps_pkg::MG_W-1:0] avg_d;

  logic [ROW_W-1:0]                              hist_rd;
  logic [aps_pkg::N_AXES-1:0][aps_pkg::MG_W-1:0] mg;
  logic [aps_pkg::N_AXES-1:0][aps_pkg::MG_W-1:0] old;
  logic                                          a_fire;

  assign a_fire = advance_i && a_valid_q;

  aps_ram #(
    .WIDTH (ROW_W),
    .DEPTH (AVG_DEPTH)
  ) u_hist (
    .clk_i   (clk_i),
    .we_i    (a_fire),
    .waddr_i (a_slot_q),
    .wdata_i (mg),
    .re_i    (accept_i),
    .raddr_i (rd_slot_q),
    .rdata_o (hist_rd)
  );

  always_comb begin
    for (int a = 0; a < aps_pkg::N_AXES; a++) begin
      mg[a]     = to_mg(a_sample_q.raw[a], cfg_i.bias_mg[a]);
      // entries not yet written on the first pass read as zero
      old[a]    = a_fill_q ? hist_rd[a*aps_pkg::MG_W +: aps_pkg::MG_W] : '0;
      sums_d[a] = sums_q[a] - SUM_W'(old[a]) + SUM_W'(mg[a]);
    end
  end

  // Divide by the window depth as a multiply by a rounded-up reciprocal
  always_comb begin
    logic [PROD_W-1:0] prod;
    for (int a = 0; a < aps_pkg::N_AXES; a++) begin
      prod     = PROD_W'(sums_q[a]) * PROD_W'(RECIP_W'(RECIP));
      avg_d[a] = prod[SHIFT +: aps_pkg::MG_W];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_slot_q <= '0;
      fill_q    <= 1'b0;
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
      sums_q    <= '0;
    end else begin
      if (accept_i) begin
        if (rd_slot_q == SLOT_W'(AVG_DEPTH - 1)) begin
          rd_slot_q <= '0;
          fill_q    <= 1'b1;
        end else begin
          rd_slot_q <= rd_slot_q + SLOT_W'(1);
        end
      end
      if (advance_i) begin
        a_valid_q <= accept_i;
        b_valid_q <= a_valid_q;
        c_valid_q <= b_valid_q;
      end
      if (a_fire) begin
        sums_q <= sums_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      a_sample_q <= sample_i;
      a_slot_q   <= rd_slot_q;
      a_fill_q   <= fill_q;
    end
    if (a_fire) begin
      b_time_q <= a_sample_q.time_us;
    end
    if (advance_i && b_valid_q) begin
      c_time_q <= b_time_q;
      c_avg_q  <= avg_d;
    end
  end

  assign avg_o.valid   = c_valid_q;
  assign avg_o.avg     = c_avg_q;
  assign avg_o.time_us = c_time_q;

endmodule

/* src/aps_detect.sv */
module aps_detect (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                advance_i,
  input  aps_pkg::avg_beat_t  avg_i,
  input  aps_pkg::cfg_t       cfg_i,
  output aps_pkg::result_t    result_o
);

  localparam int unsigned MG_W = aps_pkg::MG_W;

  logic [aps_pkg::N_AXES-1:0][MG_W-1:0] low_q, low_d;
  logic [aps_pkg::N_AXES-1:0][MG_W-1:0] high_q, high_d;
  logic [aps_pkg::N_AXES-1:0][MG_W-1:0] thr_q, thr_d;
  logic [aps_pkg::N_AXES-1:0][MG_W-1:0] swing;
  aps_pkg::aps_axis_e                   axis_q, axis_d, pick;
  logic [MG_W-1:0]                      level_q, level_d;
  logic [aps_pkg::TIME_W-1:0]           last_time_q, last_time_d;
  logic [aps_pkg::COUNT_W-1:0]          steps_q, steps_d;
  logic                                 valid_q;
  logic                                 seen_q, seen_d;

  logic                                 boundary;
  logic [MG_W-1:0]                      prev, cur, delta, thr_sel;
  logic                                 moved;
  logic                                 fire;

  assign fire = advance_i && avg_i.valid;
  assign boundary = (avg_i.time_us - last_time_q) >= cfg_i.window_interval_us;

  always_comb begin
    for (int a = 0; a < aps_pkg::N_AXES; a++) begin
      swing[a] = high_q[a] - low_q[a];
      if (boundary) begin
        thr_d[a]  = MG_W'(({1'b0, low_q[a]} + {1'b0, high_q[a]}) >> 1);
        low_d[a]  = avg_i.avg[a];
        high_d[a] = avg_i.avg[a];
      end else begin
        thr_d[a]  = thr_q[a];
        low_d[a]  = (low_q[a] > avg_i.avg[a]) ? avg_i.avg[a] : low_q[a];
        high_d[a] = (high_q[a] < avg_i.avg[a]) ? avg_i.avg[a] : high_q[a];
      end
    end

    // widest swing wins, ties to x then y
    if (swing[0] >= swing[1] && swing[0] >= swing[2]) begin
      pick = aps_pkg::AXIS_X;
    end else if (swing[1] >= swing[2]) begin
      pick = aps_pkg::AXIS_Y;
    end else begin
      pick = aps_pkg::AXIS_Z;
    end

    axis_d      = boundary ? pick : axis_q;
    last_time_d = boundary ? avg_i.time_us : last_time_q;
    // a change of axis restarts the accepted level on the new axis
    prev        = (boundary && pick != axis_q) ? avg_i.avg[pick] : level_q;
    cur         = avg_i.avg[axis_d];
    thr_sel     = thr_d[axis_d];
    delta       = (cur >= prev) ? (cur - prev) : (prev - cur);
    moved       = delta > cfg_i.step_precision;
    level_d     = moved ? cur : prev;
    seen_d      = moved && (prev > thr_sel) && (cur < thr_sel);
    steps_d     = steps_q + aps_pkg::COUNT_W'(seen_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q       <= '0;
      high_q      <= '0;
      thr_q       <= '0;
      axis_q      <= aps_pkg::AXIS_X;
      level_q     <= '0;
      last_time_q <= '0;
      steps_q     <= '0;
      valid_q     <= 1'b0;
      seen_q      <= 1'b0;
    end else begin
      if (advance_i) begin
        valid_q <= avg_i.valid;
      end
      if (fire) begin
        low_q       <= low_d;
        high_q      <= high_d;
        thr_q       <= thr_d;
        axis_q      <= axis_d;
        level_q     <= level_d;
        last_time_q <= last_time_d;
        steps_q     <= steps_d;
        seen_q      <= seen_d;
      end
    end
  end

  assign result_o.valid       = valid_q;
  assign result_o.steps_total = steps_q;
  assign result_o.step_seen   = seen_q;
  assign result_o.axis_in_use = axis_q;

endmodule

/* src/accel_pedometer_step_detector_top.sv */
// Path: an accepted sample passes stages A, B and C, then the stage D result register.
// Throughput: one sample beat per cycle; the four-stage pipeline moves as one and holds
//   only while a finished result waits on the output.
// Reset: rst_ni asynchronous, active low; clears all detector state, sums, ring position
//   and registers to their defaults. History entries read as zero until first written.
module accel_pedometer_step_detector_top #(
  parameter int unsigned AVG_DEPTH = aps_pkg::AVG_DEPTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  aps_in_if.sink                            sample_i,
  aps_out_if.source                         result_o,
  input  logic                              cfg_we_i,
  input  logic [aps_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [aps_pkg::CFG_DATA_W-1:0]    cfg_wdata_i
);

  // Pipeline outline
  //   stage A: sample captured, history entry for this ring slot read from RAM
  //   stage B: milli-g conversion per axis, running sum update, history write-back
  //   stage C: moving average via reciprocal multiply
  //   stage D: window marks, thresholds, axis choice, step decision, result register

  aps_pkg::cfg_t       cfg_q;
  aps_pkg::sample_t    sample;
  aps_pkg::avg_beat_t  avg_beat;
  aps_pkg::result_t    result;
  logic                advance;
  logic                accept;

  // Advance the whole pipeline whenever the result register is free or being drained
  assign advance        = !result.valid || result_o.ready;
  assign sample_i.ready = advance;
  assign accept         = sample_i.valid && advance;

  assign sample.raw[0]  = sample_i.raw_x;
  assign sample.raw[1]  = sample_i.raw_y;
  assign sample.raw[2]  = sample_i.raw_z;
  assign sample.time_us = sample_i.time_us;

  // Configuration registers; writes to unused indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.step_precision     <= aps_pkg::STEP_PRECISION_RST;
      cfg_q.window_interval_us <= aps_pkg::WINDOW_INTERVAL_RST;
      cfg_q.bias_mg            <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        aps_pkg::REG_STEP_PRECISION: begin
          cfg_q.step_precision <= cfg_wdata_i[aps_pkg::MG_W-1:0];
        end
        aps_pkg::REG_WINDOW_INTERVAL: begin
          cfg_q.window_interval_us <= cfg_wdata_i[aps_pkg::TIME_W-1:0];
        end
        aps_pkg::REG_BIAS_X: begin
          cfg_q.bias_mg[0] <= cfg_wdata_i[aps_pkg::MG_W-1:0];
        end
        aps_pkg::REG_BIAS_Y: begin
          cfg_q.bias_mg[1] <= cfg_wdata_i[aps_pkg::MG_W-1:0];
        end
        aps_pkg::REG_BIAS_Z: begin
          cfg_q.bias_mg[2] <= cfg_wdata_i[aps_pkg::MG_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Stages A to C: conversion, ring of past values, running sums, averages
  aps_front #(
    .AVG_DEPTH (AVG_DEPTH)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .accept_i  (accept),
    .sample_i  (sample),
    .cfg_i     (cfg_q),
    .avg_o     (avg_beat)
  );

  // Stage D: dynamic threshold and step counting
  aps_detect u_detect (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .avg_i     (avg_beat),
    .cfg_i     (cfg_q),
    .result_o  (result)
  );

  // Result beat straight from the stage D registers
  assign result_o.valid       = result.valid;
  assign result_o.steps_total = result.steps_total;
  assign result_o.step_seen   = result.step_seen;
  assign result_o.axis_in_use = result.axis_in_use;

endmodule

/* test/tb_accel_pedometer_step_detector_top.sv */
`timescale 1ns / 1ps

module tb_accel_pedometer_step_detector_top;
  import aps_pkg::*;

  // Moving-average depth of the block under test
  localparam int unsigned DEPTH        = AVG_DEPTH_DEF;
  // Cycles to let the pipeline settle after the last result beat
  localparam int          SETTLE_CYCLES = 8;
  // Cycles with no beat and no register write before the run is abandoned
  localparam int          QUIET_LIMIT   = 5000;

  typedef struct {
    logic [COUNT_W-1:0] steps;
    logic               seen;
    aps_axis_e          axis;
  } step_report_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  aps_in_if  smp_if ();
  aps_out_if res_if ();

  accel_pedometer_step_detector_top u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .sample_i    (smp_if),
    .result_o    (res_if),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Step tracker: our own copy of the detector state and its registers
  // ---------------------------------------------------------------------------
  logic [MG_W-1:0]          hist [N_AXES][DEPTH];
  logic [4:0]               ring_pos;
  logic [16:0]              run_sum [N_AXES];
  logic [MG_W-1:0]          low_mark [N_AXES];
  logic [MG_W-1:0]          high_mark [N_AXES];
  logic [MG_W-1:0]          thresh [N_AXES];
  aps_axis_e                tracked_axis;
  logic [MG_W-1:0]          held_level;
  logic [TIME_W-1:0]        last_window;
  logic [COUNT_W-1:0]       tracked_steps;
  logic [MG_W-1:0]          precision_cfg;
  logic [TIME_W-1:0]        interval_cfg;
  logic signed [MG_W-1:0]   bias_cfg [N_AXES];

  // Reports still owed by the block, oldest first
  step_report_t step_reports_q [$];

  int                fail_count     = 0;
  int                quiet_cycles   = 0;
  int                send_idle_pct  = 0;
  int                recv_stall_pct = 0;
  logic [TIME_W-1:0] stamp_us       = '0;

  // |raw * 1000 / 16384 - bias| in milli-g, truncated toward zero, saturated
  function automatic logic [MG_W-1:0] raw_to_mg(input logic signed [RAW_W-1:0] raw,
                                                input logic signed [MG_W-1:0]  bias);
    int num;
    int mag;
    num = int'(raw) * int'(MG_PER_G) - int'(bias) * (1 << FRAC_BITS);
    mag = (num < 0) ? -num : num;
    mag = mag / (1 << FRAC_BITS);
    return (mag > int'(MG_MAX)) ? MG_W'(MG_MAX) : MG_W'(mag);
  endfunction

  function automatic logic signed [RAW_W-1:0] clamp_raw(input int v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return RAW_W'(v);
  endfunction

  task automatic clear_tracker();
    for (int a = 0; a < N_AXES; a++) begin
      for (int s = 0; s < DEPTH; s++) hist[a][s] = '0;
      run_sum[a]   = '0;
      low_mark[a]  = '0;
      high_mark[a] = '0;
      thresh[a]    = '0;
      bias_cfg[a]  = '0;
    end
    ring_pos      = '0;
    tracked_axis  = AXIS_X;
    held_level    = '0;
    last_window   = '0;
    tracked_steps = '0;
    precision_cfg = STEP_PRECISION_RST;
    interval_cfg  = WINDOW_INTERVAL_RST;
  endtask

  // Advance the tracker by one sample beat and queue the report it owes
  task automatic advance_step_tracker(input logic signed [RAW_W-1:0] rx, ry, rz,
                                      input logic [TIME_W-1:0]        now);
    logic signed [RAW_W-1:0] raw [N_AXES];
    logic [MG_W-1:0]         mg;
    logic [MG_W-1:0]         avg [N_AXES];
    int                      swing [N_AXES];
    aps_axis_e               pick;
    logic [TIME_W-1:0]       elapsed;
    int                      diff;
    step_report_t            rep;
    raw[0]   = rx;
    raw[1]   = ry;
    raw[2]   = rz;
    rep.seen = 1'b0;

    // Slide each axis window along by one sample
    for (int a = 0; a < N_AXES; a++) begin
      mg                  = raw_to_mg(raw[a], bias_cfg[a]);
      run_sum[a]          = run_sum[a] - 17'(hist[a][ring_pos]) + 17'(mg);
      hist[a][ring_pos]   = mg;
      avg[a]              = MG_W'(run_sum[a] / DEPTH);
    end
    ring_pos = (ring_pos == DEPTH - 1) ? '0 : ring_pos + 5'd1;

    elapsed = now - last_window;
    if (elapsed >= interval_cfg) begin
      // Window boundary: take thresholds, pick the widest swing, restart marks
      last_window = now;
      for (int a = 0; a < N_AXES; a++) begin
        thresh[a]    = MG_W'((int'(low_mark[a]) + int'(high_mark[a])) / 2);
        swing[a]     = int'(high_mark[a]) - int'(low_mark[a]);
        low_mark[a]  = avg[a];
        high_mark[a] = avg[a];
      end
      if (swing[0] >= swing[1] && swing[0] >= swing[2]) pick = AXIS_X;
      else if (swing[1] >= swing[2]) pick = AXIS_Y;
      else pick = AXIS_Z;
      if (pick != tracked_axis) held_level = avg[pick];
      tracked_axis = pick;
    end else begin
      for (int a = 0; a < N_AXES; a++) begin
        if (low_mark[a] > avg[a]) low_mark[a] = avg[a];
        if (high_mark[a] < avg[a]) high_mark[a] = avg[a];
      end
    end

    // Count a step on a large enough move that falls through the threshold
    diff = int'(avg[tracked_axis]) - int'(held_level);
    if (diff > int'(precision_cfg) || diff < -int'(precision_cfg)) begin
      if (held_level > thresh[tracked_axis] && avg[tracked_axis] < thresh[tracked_axis]) begin
        tracked_steps = tracked_steps + 1'b1;
        rep.seen      = 1'b1;
      end
      held_level = avg[tracked_axis];
    end

    rep.steps = tracked_steps;
    rep.axis  = tracked_axis;
    step_reports_q.push_back(rep);
  endtask

  task automatic check_step_report();
    step_report_t want;
    if (step_reports_q.size() == 0) begin
      $error("result beat with no sample pending: steps_total %0d", res_if.steps_total);
      fail_count++;
    end else begin
      want = step_reports_q.pop_front();
      if (res_if.steps_total !== want.steps) begin
        $error("steps_total: expected %0d, got %0d", want.steps, res_if.steps_total);
        fail_count++;
      end
      if (res_if.step_seen !== want.seen) begin
        $error("step_seen: expected %0d, got %0d", want.seen, res_if.step_seen);
        fail_count++;
      end
      if (res_if.axis_in_use !== want.axis) begin
        $error("axis_in_use: expected %0d, got %0d", want.axis, res_if.axis_in_use);
        fail_count++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: everything observed at the rising edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    // Check the result beat first so a sample taken this edge cannot match it
    if (res_if.valid && res_if.ready) check_step_report();
    if (smp_if.valid && smp_if.ready)
      advance_step_tracker(smp_if.raw_x, smp_if.raw_y, smp_if.raw_z, smp_if.time_us);
    if (cfg_we) begin
      case (cfg_idx)
        REG_STEP_PRECISION:  precision_cfg   = cfg_wdata[MG_W-1:0];
        REG_WINDOW_INTERVAL: interval_cfg    = cfg_wdata;
        REG_BIAS_X:          bias_cfg[AXIS_X] = cfg_wdata[MG_W-1:0];
        REG_BIAS_Y:          bias_cfg[AXIS_Y] = cfg_wdata[MG_W-1:0];
        REG_BIAS_Z:          bias_cfg[AXIS_Z] = cfg_wdata[MG_W-1:0];
        default: ;
      endcase
    end

    // Watchdog: any beat or register write counts as progress
    if ((res_if.valid && res_if.ready) || (smp_if.valid && smp_if.ready) || cfg_we)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("** accel_pedometer_step_detector_top: FAILED **");
      $finish;
    end
  end

  // Receiver: stall at random, decided on the falling edge
  always @(negedge clk) begin
    res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Offer one sample beat and hold it until taken; valid is left high on exit
  task automatic send_sample(input logic signed [RAW_W-1:0] rx, ry, rz,
                             input logic [TIME_W-1:0]        t);
    while ($urandom_range(99) < send_idle_pct) begin
      smp_if.valid <= 1'b0;
      @(negedge clk);
    end
    smp_if.valid   <= 1'b1;
    smp_if.raw_x   <= rx;
    smp_if.raw_y   <= ry;
    smp_if.raw_z   <= rz;
    smp_if.time_us <= t;
    @(posedge clk);
    while (!smp_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Drop valid and hold until every owed report has come back, then settle
  task automatic wait_drained();
    smp_if.valid <= 1'b0;
    while (step_reports_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Write all five registers once the block is idle
  task automatic configure(input int precision, input logic [TIME_W-1:0] interval,
                           input int bx, input int by, input int bz);
    aps_reg_e              idx [5];
    logic [CFG_DATA_W-1:0] val [5];
    idx = '{REG_STEP_PRECISION, REG_WINDOW_INTERVAL, REG_BIAS_X, REG_BIAS_Y, REG_BIAS_Z};
    val = '{CFG_DATA_W'(precision), interval, CFG_DATA_W'(bx), CFG_DATA_W'(by),
            CFG_DATA_W'(bz)};
    wait_drained();
    for (int i = 0; i < 5; i++) begin
      cfg_we    <= 1'b1;
      cfg_idx   <= idx[i];
      cfg_wdata <= val[i];
      @(negedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // Walking-like motion: one axis carries a triangle wave, the others jitter
  // around a resting level. A few beats are full-range noise, some with a
  // timestamp jump. Each segment of a walk draws fresh shape parameters.
  task automatic run_walk(input int total);
    int        sent;
    int        len;
    int        period;
    int        amp;
    int        step_us;
    int        phase;
    int        ramp;
    int        lead;
    int        base [N_AXES];
    int        val [N_AXES];
    sent = 0;
    while (sent < total) begin
      len     = $urandom_range(30, 120);
      if (len > total - sent) len = total - sent;
      lead    = $urandom_range(2);
      period  = $urandom_range(20, 80);
      amp     = $urandom_range(4000, 20000);
      step_us = $urandom_range(8000, 12000);
      phase   = $urandom_range(period - 1);
      for (int a = 0; a < N_AXES; a++) base[a] = int'($urandom_range(32000)) - 16000;
      repeat (len) begin
        ramp = (phase < period / 2) ? phase : period - phase;
        for (int a = 0; a < N_AXES; a++) val[a] = base[a] + int'($urandom_range(600)) - 300;
        val[lead] += amp * (4 * ramp - period) / period;
        stamp_us += TIME_W'(step_us);
        if ($urandom_range(99) < 8) begin
          for (int a = 0; a < N_AXES; a++) val[a] = int'($urandom_range(65535)) - 32768;
          if ($urandom_range(3) == 0) stamp_us = $urandom();
        end
        send_sample(clamp_raw(val[0]), clamp_raw(val[1]), clamp_raw(val[2]), stamp_us);
        phase = (phase + 1) % period;
      end
      sent += len;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset registers; raw extremes, exact interval and a window across the wrap
  task automatic test_field_extremes();
    send_sample(16'sd32767, 16'sd32767, 16'sd32767, 32'd0);
    send_sample(-16'sd32768, -16'sd32768, -16'sd32768, 32'd1000);
    send_sample(16'sd0, 16'sd0, 16'sd0, 32'd499999);
    // elapsed equals the interval: a boundary
    send_sample(-16'sd1, 16'sd1, -16'sd1, 32'd500000);
    send_sample(16'sd32767, -16'sd32768, 16'sd0, 32'hFFFF_FFFF);
    // exactly one interval measured across the timestamp wrap
    send_sample(16'sd0, 16'sd16384, -16'sd16384, 32'h0007_A11F);
    send_sample(-16'sd16384, 16'sd0, 16'sd16384, 32'h0007_A120);
  endtask

  // Interval of zero, then bursts that move the active axis from y to z to x
  task automatic test_window_special_cases();
    int v [N_AXES];
    int lead;
    configure(0, 32'd0, 0, 0, 0);
    send_sample(16'sd16384, 16'sd0, 16'sd0, 32'd10);
    send_sample(-16'sd16384, 16'sd8000, 16'sd0, 32'd10);
    send_sample(16'sd0, 16'sd32767, 16'sd0, 32'd5);
    configure(0, 32'd2000, 0, 0, 0);
    stamp_us = 32'd5;
    for (int k = 0; k < 10; k++) begin
      lead = (k / 4 + 1) % N_AXES;
      for (int a = 0; a < N_AXES; a++) v[a] = 0;
      v[lead] = (k % 2) ? 32767 : 0;
      stamp_us += 32'd1000;
      send_sample(clamp_raw(v[0]), clamp_raw(v[1]), clamp_raw(v[2]), stamp_us);
    end
  endtask

  // Bias and precision at their limits, interval at one and at its maximum
  task automatic test_bias_precision_extremes();
    configure(4095, 32'd1, -2000, 2000, -1);
    send_sample(16'sd12000, -16'sd12000, 16'sd0, 32'd100);
    send_sample(-16'sd32768, 16'sd32767, 16'sd5, 32'd101);
    configure(0, 32'hFFFF_FFFF, 2000, -2000, 1);
    send_sample(16'sd32767, -16'sd32768, -16'sd5, 32'd102);
    send_sample(-16'sd9000, 16'sd9000, 16'sd20000, 32'd101);
  endtask

  // Bulk of the run: walks under each idling pattern, extreme then live settings
  task automatic test_random_walks();
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
        default: begin send_idle_pct = 10; recv_stall_pct = 10; end
      endcase
      configure((ph % 2) ? 4095 : 0, (ph % 2) ? 32'hFFFF_FFFF : 32'd1,
                int'($urandom_range(4000)) - 2000, int'($urandom_range(4000)) - 2000,
                int'($urandom_range(4000)) - 2000);
      run_walk(80);
      configure($urandom_range(40, 300), $urandom_range(100000, 800000),
                int'($urandom_range(4000)) - 2000, int'($urandom_range(4000)) - 2000,
                int'($urandom_range(4000)) - 2000);
      run_walk(270);
    end
  endtask

  // Hold the sender mid-stream until the receiver has caught up completely
  task automatic test_drain_pause();
    send_idle_pct  = 0;
    recv_stall_pct = 70;
    configure(150, 32'd400000, 0, 0, 0);
    run_walk(60);
    wait_drained();
    run_walk(60);
  endtask

  initial begin
    smp_if.valid   = 1'b0;
    smp_if.raw_x   = '0;
    smp_if.raw_y   = '0;
    smp_if.raw_z   = '0;
    smp_if.time_us = '0;
    res_if.ready   = 1'b0;
    cfg_we         = 1'b0;
    cfg_idx        = '0;
    cfg_wdata      = '0;
    rst_n          = 1'b0;
    clear_tracker();
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    test_field_extremes();
    test_window_special_cases();
    test_bias_precision_extremes();
    test_random_walks();
    test_drain_pause();

    // Drain the tail; the watchdog bounds this wait
    wait_drained();
    if (fail_count == 0) begin
      $display("** accel_pedometer_step_detector_top: PASSED **");
    end else begin
      $display("** accel_pedometer_step_detector_top: FAILED **");
    end
    $finish;
  end

endmodule
